@@ rtl/elg_pkg.sv @@
// ----------------------------------------------------------------------------
// elg_pkg: shared definitions for the ElGamal block
// Widths, register indexes, datapath opcodes, register ids and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package elg_pkg;

  // operand width used by the arithmetic (fields are used in their low WIDTH bits)
  localparam int WIDTH     = 32;
  localparam int FIELD_W   = 32;
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVKEY   = 2'd2;

  // configuration reset values
  localparam logic [FIELD_W-1:0] RST_MODULUS   = 32'd2147483647;
  localparam logic [FIELD_W-1:0] RST_GENERATOR = 32'd2;
  localparam logic [FIELD_W-1:0] RST_PRIVKEY   = 32'd1;

  // datapath opcodes
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_CLEAR    = 4'd2;
  localparam logic [3:0] OP_MUL      = 4'd3;
  localparam logic [3:0] OP_DIV      = 4'd4;
  localparam logic [3:0] OP_POW_INIT = 4'd5;
  localparam logic [3:0] OP_EXP_SHR  = 4'd6;
  localparam logic [3:0] OP_COPY     = 4'd7;
  localparam logic [3:0] OP_EUC_INIT = 4'd8;
  localparam logic [3:0] OP_EUC_STEP = 4'd9;
  localparam logic [3:0] OP_FAIL     = 4'd10;

  // datapath register ids
  localparam logic [4:0] RID_Q    = 5'd0;
  localparam logic [4:0] RID_G    = 5'd1;
  localparam logic [4:0] RID_X    = 5'd2;
  localparam logic [4:0] RID_K    = 5'd3;
  localparam logic [4:0] RID_MSG  = 5'd4;
  localparam logic [4:0] RID_ACC  = 5'd5;
  localparam logic [4:0] RID_BASE = 5'd6;
  localparam logic [4:0] RID_Y    = 5'd7;
  localparam logic [4:0] RID_C1   = 5'd8;
  localparam logic [4:0] RID_C2   = 5'd9;
  localparam logic [4:0] RID_KR   = 5'd10;
  localparam logic [4:0] RID_RP   = 5'd11;
  localparam logic [4:0] RID_RC   = 5'd12;
  localparam logic [4:0] RID_TC   = 5'd13;
  localparam logic [4:0] RID_QUO  = 5'd14;
  localparam logic [4:0] RID_RN   = 5'd15;
  localparam logic [4:0] RID_PR   = 5'd16;
  localparam logic [4:0] RID_DEC  = 5'd17;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] dst;
  } elg_cmd_t;

  typedef struct packed {
    logic done;
    logic q_bad;
    logic exp_zero;
    logic exp_lsb;
    logic rc_zero;
    logic rc_one;
  } elg_stat_t;

endpackage
`default_nettype wire

@@ rtl/elg_dpath.sv @@
// ----------------------------------------------------------------------------
// elg_dpath: ElGamal datapath
// Working registers plus one bit-serial unit that does modular multiply
// (shift-add with reduction) or restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module elg_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire elg_pkg::elg_cmd_t             cmd,
  output elg_pkg::elg_stat_t                 stat,
  input  wire logic [elg_pkg::FIELD_W-1:0]   q_in,
  input  wire logic [elg_pkg::FIELD_W-1:0]   g_in,
  input  wire logic [elg_pkg::FIELD_W-1:0]   x_in,
  input  wire logic [elg_pkg::FIELD_W-1:0]   k_in,
  input  wire logic [elg_pkg::FIELD_W-1:0]   msg_in,
  output logic [elg_pkg::WIDTH-1:0]          y_o,
  output logic [elg_pkg::WIDTH-1:0]          c1_o,
  output logic [elg_pkg::WIDTH-1:0]          c2_o,
  output logic [elg_pkg::WIDTH-1:0]          kr_o,
  output logic [elg_pkg::WIDTH-1:0]          dec_o,
  output logic                               flag_o
);
  localparam int W = elg_pkg::WIDTH;
  localparam int CW = elg_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic [W-1:0] q_r, g_r, x_r, k_r, msg_r, acc_r, base_r, y_r, c1_r, c2_r, kr_r;
  logic [W-1:0] rp_r, rc_r, tp_r, tc_r, quo_r, rn_r, pr_r, dec_r, exp_r;
  logic         flag_r;

  // serial unit state
  logic          eng_busy_r, done_r, mode_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  s_r, d_r, eacc_r, equo_r;
  logic [4:0]    dst_r;

  logic [W-1:0] a_val, b_val;
  logic         eng_start, eng_last;

  // operand select
  function automatic logic [W-1:0] pick(input logic [4:0] id,
      input logic [W-1:0] q, g, x, k, m, acc, base, y, c1, c2, kr,
      input logic [W-1:0] rp, rc, tc, quo, pr);
    logic [W-1:0] v;
    case (id)
      elg_pkg::RID_Q:    v = q;
      elg_pkg::RID_G:    v = g;
      elg_pkg::RID_X:    v = x;
      elg_pkg::RID_K:    v = k;
      elg_pkg::RID_MSG:  v = m;
      elg_pkg::RID_ACC:  v = acc;
      elg_pkg::RID_BASE: v = base;
      elg_pkg::RID_Y:    v = y;
      elg_pkg::RID_C1:   v = c1;
      elg_pkg::RID_C2:   v = c2;
      elg_pkg::RID_KR:   v = kr;
      elg_pkg::RID_RP:   v = rp;
      elg_pkg::RID_RC:   v = rc;
      elg_pkg::RID_TC:   v = tc;
      elg_pkg::RID_QUO:  v = quo;
      elg_pkg::RID_PR:   v = pr;
      default:           v = '0;
    endcase
    return v;
  endfunction

  assign a_val = pick(cmd.a, q_r, g_r, x_r, k_r, msg_r, acc_r, base_r, y_r, c1_r, c2_r,
                      kr_r, rp_r, rc_r, tc_r, quo_r, pr_r);
  assign b_val = pick(cmd.b, q_r, g_r, x_r, k_r, msg_r, acc_r, base_r, y_r, c1_r, c2_r,
                      kr_r, rp_r, rc_r, tc_r, quo_r, pr_r);

  assign eng_start = (cmd.op == elg_pkg::OP_MUL) || (cmd.op == elg_pkg::OP_DIV);
  assign eng_last  = eng_busy_r && (cnt_r == CNT_LAST);

  // one step of the serial unit
  logic [W+1:0] mul_sum, m1, m2, q_ext;
  logic [W:0]   rem_ext, d_ext, rem_n;
  logic         ge;
  logic [W-1:0] eacc_nxt, equo_nxt;

  always_comb begin
    q_ext   = {2'b00, q_r};
    mul_sum = {1'b0, eacc_r, 1'b0} + (s_r[W-1] ? {2'b00, d_r} : '0);
    m1      = (mul_sum >= q_ext) ? mul_sum - q_ext : mul_sum;
    m2      = (m1 >= q_ext) ? m1 - q_ext : m1;
    rem_ext = {eacc_r, s_r[W-1]};
    d_ext   = {1'b0, d_r};
    ge      = (rem_ext >= d_ext);
    rem_n   = ge ? rem_ext - d_ext : rem_ext;
    eacc_nxt = mode_r ? rem_n[W-1:0] : m2[W-1:0];
    equo_nxt = {equo_r[W-2:0], ge};
  end

  // modular subtract for the Euclid coefficient
  logic [W:0] tsub;
  always_comb begin
    if (tp_r >= pr_r) tsub = {1'b0, tp_r} - {1'b0, pr_r};
    else              tsub = {1'b0, tp_r} + {1'b0, q_r} - {1'b0, pr_r};
  end

  // write port shared by serial-unit results and copies
  logic         wr_en;
  logic [4:0]   wr_id;
  logic [W-1:0] wr_val;
  always_comb begin
    wr_en  = 1'b0;
    wr_id  = cmd.dst;
    wr_val = a_val;
    if (eng_last) begin
      wr_en  = 1'b1;
      wr_id  = dst_r;
      wr_val = eacc_nxt;
    end else if (cmd.op == elg_pkg::OP_COPY) begin
      wr_en  = 1'b1;
    end
  end

  // control of the serial unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_busy_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r <= eng_last;
      if (eng_start)     eng_busy_r <= 1'b1;
      else if (eng_last) eng_busy_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (eng_start) begin
      mode_r <= (cmd.op == elg_pkg::OP_DIV);
      s_r    <= (cmd.op == elg_pkg::OP_DIV) ? a_val : b_val;
      d_r    <= (cmd.op == elg_pkg::OP_DIV) ? b_val : a_val;
      eacc_r <= '0;
      equo_r <= '0;
      cnt_r  <= '0;
      dst_r  <= cmd.dst;
    end else if (eng_busy_r) begin
      s_r    <= {s_r[W-2:0], 1'b0};
      eacc_r <= eacc_nxt;
      equo_r <= equo_nxt;
      cnt_r  <= cnt_r + 1'b1;
    end
    if (eng_last && mode_r) quo_r <= equo_nxt;

    if (wr_en) begin
      case (wr_id)
        elg_pkg::RID_MSG:  msg_r  <= wr_val;
        elg_pkg::RID_ACC:  acc_r  <= wr_val;
        elg_pkg::RID_BASE: base_r <= wr_val;
        elg_pkg::RID_Y:    y_r    <= wr_val;
        elg_pkg::RID_C1:   c1_r   <= wr_val;
        elg_pkg::RID_C2:   c2_r   <= wr_val;
        elg_pkg::RID_KR:   kr_r   <= wr_val;
        elg_pkg::RID_RC:   rc_r   <= wr_val;
        elg_pkg::RID_TC:   tc_r   <= wr_val;
        elg_pkg::RID_RN:   rn_r   <= wr_val;
        elg_pkg::RID_PR:   pr_r   <= wr_val;
        elg_pkg::RID_DEC:  dec_r  <= wr_val;
        default: ;
      endcase
    end

    case (cmd.op)
      elg_pkg::OP_LOAD: begin
        q_r    <= q_in[W-1:0];
        g_r    <= g_in[W-1:0];
        x_r    <= x_in[W-1:0];
        k_r    <= k_in[W-1:0];
        msg_r  <= msg_in[W-1:0];
        dec_r  <= '0;
        flag_r <= 1'b0;
      end
      elg_pkg::OP_CLEAR: begin
        y_r    <= '0;
        c1_r   <= '0;
        c2_r   <= '0;
        kr_r   <= '0;
        dec_r  <= '0;
        flag_r <= 1'b1;
      end
      elg_pkg::OP_POW_INIT: begin
        acc_r <= W'(1);
        exp_r <= a_val;
      end
      elg_pkg::OP_EXP_SHR: exp_r <= {1'b0, exp_r[W-1:1]};
      elg_pkg::OP_EUC_INIT: begin
        rp_r <= q_r;
        rc_r <= kr_r;
        tp_r <= '0;
        tc_r <= W'(1);
      end
      elg_pkg::OP_EUC_STEP: begin
        rp_r <= rc_r;
        rc_r <= rn_r;
        tp_r <= tc_r;
        tc_r <= tsub[W-1:0];
      end
      elg_pkg::OP_FAIL: begin
        dec_r  <= '0;
        flag_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // status back to the controller
  assign stat = '{done:     done_r,
                  q_bad:    (q_r[W-1:1] == '0),
                  exp_zero: (exp_r == '0),
                  exp_lsb:  exp_r[0],
                  rc_zero:  (rc_r == '0),
                  rc_one:   (rc_r == W'(1))};

  assign y_o    = y_r;
  assign c1_o   = c1_r;
  assign c2_o   = c2_r;
  assign kr_o   = kr_r;
  assign dec_o  = dec_r;
  assign flag_o = flag_r;

endmodule
`default_nettype wire

@@ rtl/elg_ctrl.sv @@
// ----------------------------------------------------------------------------
// elg_ctrl: ElGamal sequencer
// Walks the four exponentiations, the ciphertext product and the
// extended-Euclid inverse and decrypt product via datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none
module elg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done_strobe,
  output elg_pkg::elg_cmd_t       cmd,
  input  wire elg_pkg::elg_stat_t stat
);
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CHECK   = 5'd1;
  localparam logic [4:0] S_P_RED   = 5'd2;
  localparam logic [4:0] S_P_INIT  = 5'd3;
  localparam logic [4:0] S_P_TEST  = 5'd4;
  localparam logic [4:0] S_P_MULA  = 5'd5;
  localparam logic [4:0] S_P_SQ    = 5'd6;
  localparam logic [4:0] S_P_SHIFT = 5'd7;
  localparam logic [4:0] S_P_DONE  = 5'd8;
  localparam logic [4:0] S_MSG_RED = 5'd9;
  localparam logic [4:0] S_C2_MUL  = 5'd10;
  localparam logic [4:0] S_E_INIT  = 5'd11;
  localparam logic [4:0] S_E_TEST  = 5'd12;
  localparam logic [4:0] S_E_DIV   = 5'd13;
  localparam logic [4:0] S_E_MUL   = 5'd14;
  localparam logic [4:0] S_E_STEP  = 5'd15;
  localparam logic [4:0] S_E_INV   = 5'd16;
  localparam logic [4:0] S_E_FAIL  = 5'd17;
  localparam logic [4:0] S_WAIT    = 5'd18;
  localparam logic [4:0] S_FIN     = 5'd19;

  logic [4:0] state_r, state_nxt, ret_r, ret_nxt;
  logic [1:0] pow_r, pow_nxt;
  logic       strobe_r, strobe_nxt;
  logic [4:0] pow_base, pow_exp, pow_dst;

  // operands of each exponentiation: y, y^k, c1, shared key
  always_comb begin
    case (pow_r)
      2'd0:    begin pow_base = elg_pkg::RID_G;  pow_exp = elg_pkg::RID_X;
                     pow_dst = elg_pkg::RID_Y;   end
      2'd1:    begin pow_base = elg_pkg::RID_Y;  pow_exp = elg_pkg::RID_K;
                     pow_dst = elg_pkg::RID_ACC; end
      2'd2:    begin pow_base = elg_pkg::RID_G;  pow_exp = elg_pkg::RID_K;
                     pow_dst = elg_pkg::RID_C1;  end
      default: begin pow_base = elg_pkg::RID_C1; pow_exp = elg_pkg::RID_X;
                     pow_dst = elg_pkg::RID_KR;  end
    endcase
  end

  // next state and command
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    pow_nxt    = pow_r;
    strobe_nxt = 1'b0;
    cmd        = '{op: elg_pkg::OP_NOP, a: elg_pkg::RID_Q, b: elg_pkg::RID_Q,
                   dst: elg_pkg::RID_Q};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = elg_pkg::OP_LOAD;
          pow_nxt   = 2'd0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.q_bad) begin
          cmd.op    = elg_pkg::OP_CLEAR;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_P_RED;
        end
      end
      // base mod q
      S_P_RED: begin
        cmd       = '{op: elg_pkg::OP_DIV, a: pow_base, b: elg_pkg::RID_Q,
                      dst: elg_pkg::RID_BASE};
        ret_nxt   = S_P_INIT;
        state_nxt = S_WAIT;
      end
      S_P_INIT: begin
        cmd.op    = elg_pkg::OP_POW_INIT;
        cmd.a     = pow_exp;
        state_nxt = S_P_TEST;
      end
      S_P_TEST: begin
        if (stat.exp_zero)     state_nxt = S_P_DONE;
        else if (stat.exp_lsb) state_nxt = S_P_MULA;
        else                   state_nxt = S_P_SQ;
      end
      S_P_MULA: begin
        cmd       = '{op: elg_pkg::OP_MUL, a: elg_pkg::RID_ACC, b: elg_pkg::RID_BASE,
                      dst: elg_pkg::RID_ACC};
        ret_nxt   = S_P_SQ;
        state_nxt = S_WAIT;
      end
      S_P_SQ: begin
        cmd       = '{op: elg_pkg::OP_MUL, a: elg_pkg::RID_BASE, b: elg_pkg::RID_BASE,
                      dst: elg_pkg::RID_BASE};
        ret_nxt   = S_P_SHIFT;
        state_nxt = S_WAIT;
      end
      S_P_SHIFT: begin
        cmd.op    = elg_pkg::OP_EXP_SHR;
        state_nxt = S_P_TEST;
      end
      S_P_DONE: begin
        cmd       = '{op: elg_pkg::OP_COPY, a: elg_pkg::RID_ACC, b: elg_pkg::RID_Q,
                      dst: pow_dst};
        pow_nxt   = pow_r + 2'd1;
        case (pow_r)
          2'd1:    state_nxt = S_MSG_RED;
          2'd3:    state_nxt = S_E_INIT;
          default: state_nxt = S_P_RED;
        endcase
      end
      S_MSG_RED: begin
        cmd       = '{op: elg_pkg::OP_DIV, a: elg_pkg::RID_MSG, b: elg_pkg::RID_Q,
                      dst: elg_pkg::RID_MSG};
        ret_nxt   = S_C2_MUL;
        state_nxt = S_WAIT;
      end
      S_C2_MUL: begin
        cmd       = '{op: elg_pkg::OP_MUL, a: elg_pkg::RID_ACC, b: elg_pkg::RID_MSG,
                      dst: elg_pkg::RID_C2};
        ret_nxt   = S_P_RED;
        state_nxt = S_WAIT;
      end
      // extended Euclid, coefficient kept mod q
      S_E_INIT: begin
        cmd.op    = elg_pkg::OP_EUC_INIT;
        state_nxt = S_E_TEST;
      end
      S_E_TEST: begin
        if (stat.rc_zero)     state_nxt = S_E_FAIL;
        else if (stat.rc_one) state_nxt = S_E_INV;
        else                  state_nxt = S_E_DIV;
      end
      S_E_DIV: begin
        cmd       = '{op: elg_pkg::OP_DIV, a: elg_pkg::RID_RP, b: elg_pkg::RID_RC,
                      dst: elg_pkg::RID_RN};
        ret_nxt   = S_E_MUL;
        state_nxt = S_WAIT;
      end
      S_E_MUL: begin
        cmd       = '{op: elg_pkg::OP_MUL, a: elg_pkg::RID_QUO, b: elg_pkg::RID_TC,
                      dst: elg_pkg::RID_PR};
        ret_nxt   = S_E_STEP;
        state_nxt = S_WAIT;
      end
      S_E_STEP: begin
        cmd.op    = elg_pkg::OP_EUC_STEP;
        state_nxt = S_E_TEST;
      end
      S_E_INV: begin
        cmd       = '{op: elg_pkg::OP_MUL, a: elg_pkg::RID_C2, b: elg_pkg::RID_TC,
                      dst: elg_pkg::RID_DEC};
        ret_nxt   = S_FIN;
        state_nxt = S_WAIT;
      end
      S_E_FAIL: begin
        cmd.op    = elg_pkg::OP_FAIL;
        state_nxt = S_FIN;
      end
      S_WAIT: begin
        if (stat.done) state_nxt = ret_r;
      end
      S_FIN: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      pow_r    <= 2'd0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      pow_r    <= pow_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign done_strobe = strobe_r;

endmodule
`default_nettype wire

@@ rtl/elgamal_encrypt_decrypt.sv @@
// ----------------------------------------------------------------------------
// elgamal_encrypt_decrypt: ElGamal encrypt and decrypt
// Per request: public key, ciphertext pair, shared key and decrypted message.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The result comes
// soonest for a modulus below two and latest for full-width exponents
// and a long Euclid run; it shows on the out_ ports for exactly one
// cycle with out_valid high; it cannot be held off and must be taken then.
// The run time is set by one bit-serial multiply/divide unit that all
// steps share: each modular product or remainder costs WIDTH steps and a
// handoff; a request runs four square-and-multiply passes (a reduction of
// the base, then a square per exponent bit up to its highest set bit and
// a product per set bit) and one Euclid pass of a division and a product
// per step. A new request may be given in the cycle that shows out_valid.
// Configuration writes are always ready.
`default_nettype none
module elgamal_encrypt_decrypt (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [elg_pkg::FIELD_W-1:0]       in_ephemeral_key,
  input  wire logic [elg_pkg::FIELD_W-1:0]       in_message,
  output logic                                   out_valid,
  output logic [elg_pkg::FIELD_W-1:0]            out_public_key,
  output logic [elg_pkg::FIELD_W-1:0]            out_cipher_first,
  output logic [elg_pkg::FIELD_W-1:0]            out_cipher_second,
  output logic [elg_pkg::FIELD_W-1:0]            out_shared_key,
  output logic [elg_pkg::FIELD_W-1:0]            out_decrypted,
  output logic                                   out_no_inverse,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [elg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [elg_pkg::FIELD_W-1:0]       cfg_data
);
  logic [elg_pkg::FIELD_W-1:0] modulus_r, generator_r, privkey_r;
  elg_pkg::elg_cmd_t  cmd;
  elg_pkg::elg_stat_t stat;
  logic [elg_pkg::WIDTH-1:0] y_w, c1_w, c2_w, kr_w, dec_w;
  logic flag_w;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= elg_pkg::RST_MODULUS;
      generator_r <= elg_pkg::RST_GENERATOR;
      privkey_r   <= elg_pkg::RST_PRIVKEY;
    end else if (cfg_valid) begin
      case (cfg_index)
        elg_pkg::CFG_MODULUS:   modulus_r   <= cfg_data;
        elg_pkg::CFG_GENERATOR: generator_r <= cfg_data;
        elg_pkg::CFG_PRIVKEY:   privkey_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  elg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done_strobe (out_valid),
    .cmd         (cmd),
    .stat        (stat)
  );

  elg_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .q_in   (modulus_r),
    .g_in   (generator_r),
    .x_in   (privkey_r),
    .k_in   (in_ephemeral_key),
    .msg_in (in_message),
    .y_o    (y_w),
    .c1_o   (c1_w),
    .c2_o   (c2_w),
    .kr_o   (kr_w),
    .dec_o  (dec_w),
    .flag_o (flag_w)
  );

  assign out_public_key    = elg_pkg::FIELD_W'(y_w);
  assign out_cipher_first  = elg_pkg::FIELD_W'(c1_w);
  assign out_cipher_second = elg_pkg::FIELD_W'(c2_w);
  assign out_shared_key    = elg_pkg::FIELD_W'(kr_w);
  assign out_decrypted     = elg_pkg::FIELD_W'(dec_w);
  assign out_no_inverse    = flag_w;

endmodule
`default_nettype wire

@@ rtl/elg_checker.sv @@
// ----------------------------------------------------------------------------
// elg_checker: port-level checks for the ElGamal block
// Request/result sequencing and the no-inverse result convention.
// ----------------------------------------------------------------------------
`default_nettype none
module elg_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        out_valid,
  input wire logic                        out_no_inverse,
  input wire logic [elg_pkg::FIELD_W-1:0] out_decrypted
);
  // an accepted request makes the block busy
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request accepted but block not busy");

  // one result per request: strobe lasts one cycle
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // result comes when the work is finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while still busy");

  // missing inverse gives a zero message
  a_noinv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_inverse |-> out_decrypted == '0)
    else $error("no inverse but decrypted value nonzero");

endmodule

bind elgamal_encrypt_decrypt elg_checker u_elg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_no_inverse (out_no_inverse),
  .out_decrypted  (out_decrypted)
);
`default_nettype wire

@@ tb/sv/tb_elgamal_encrypt_decrypt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elgamal_encrypt_decrypt: self-checking bench for the ElGamal block
// Programs modulus, generator and private key over the cfg port, sends
// requests of ephemeral key and message, and checks each result field by
// field against an in-bench predictor of the encrypt/decrypt arithmetic.
// ----------------------------------------------------------------------------
module tb_elgamal_encrypt_decrypt;
  import elg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register here
  localparam int  MAX_CYCLES = 8_000_000;
  localparam int  SETTLE     = 40;

  typedef struct packed {
    logic [FIELD_W-1:0] public_key;
    logic [FIELD_W-1:0] cipher_first;
    logic [FIELD_W-1:0] cipher_second;
    logic [FIELD_W-1:0] shared_key;
    logic [FIELD_W-1:0] decrypted;
    logic               no_inverse;
  } elg_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [FIELD_W-1:0] in_ephemeral_key, in_message;
  logic out_valid;
  logic [FIELD_W-1:0] out_public_key, out_cipher_first, out_cipher_second;
  logic [FIELD_W-1:0] out_shared_key, out_decrypted;
  logic out_no_inverse;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FIELD_W-1:0] cfg_data;

  // predictor copy of the configuration
  logic [FIELD_W-1:0] q_reg, g_reg, x_reg;

  elg_result_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_noinv = 0;
  int cycles = 0;
  int gap_pct = 0;

  elgamal_encrypt_decrypt DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ephemeral_key(in_ephemeral_key), .in_message(in_message),
    .out_valid(out_valid), .out_public_key(out_public_key),
    .out_cipher_first(out_cipher_first), .out_cipher_second(out_cipher_second),
    .out_shared_key(out_shared_key), .out_decrypted(out_decrypted),
    .out_no_inverse(out_no_inverse),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- arithmetic predictor ----------------
  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b,
                                         logic [63:0] m);
    return ((a % m) * (b % m)) % m;
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] base_v, logic [63:0] ex,
                                         logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % m;
    sq  = base_v % m;
    while (ex != 0) begin
      if (ex[0]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
      ex = ex >> 1;
    end
    return acc;
  endfunction

  // extended Euclid; ok=0 when v has no inverse mod m
  function automatic logic [63:0] invmod(logic [63:0] v, logic [63:0] m,
                                         output bit ok);
    longint r_p, r_c, t_p, t_c, quo, r_n, t_n, t;
    r_p = longint'(m);
    r_c = longint'(v % m);
    t_p = 0;
    t_c = 1;
    while (r_c != 0 && r_c != 1) begin
      quo = r_p / r_c;
      r_n = r_p - quo * r_c;
      t_n = t_p - quo * t_c;
      r_p = r_c; r_c = r_n;
      t_p = t_c; t_c = t_n;
    end
    ok = (r_c == 1);
    t = t_c % longint'(m);
    if (t < 0) t += longint'(m);
    return ok ? 64'(t) : 64'd0;
  endfunction

  function automatic elg_result_t predict_encdec(logic [FIELD_W-1:0] eph,
                                                 logic [FIELD_W-1:0] msg);
    elg_result_t r;
    logic [63:0] q, y, c1, kk, c2, kr, inv;
    bit ok;
    q = 64'(q_reg);
    r = '0;
    if (q < 2) begin
      r.no_inverse = 1'b1;
      return r;
    end
    y               = powmod(64'(g_reg), 64'(x_reg), q);
    r.public_key    = FIELD_W'(y);
    kk              = powmod(y, 64'(eph), q);
    c1              = powmod(64'(g_reg), 64'(eph), q);
    r.cipher_first  = FIELD_W'(c1);
    c2              = mulmod(kk, 64'(msg), q);
    r.cipher_second = FIELD_W'(c2);
    kr              = powmod(c1, 64'(x_reg), q);
    r.shared_key    = FIELD_W'(kr);
    inv             = invmod(kr, q, ok);
    if (ok) r.decrypted = FIELD_W'(mulmod(c2, inv, q));
    else    r.no_inverse = 1'b1;
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_request(logic [FIELD_W-1:0] eph, logic [FIELD_W-1:0] msg);
    int gap;
    start            <= 1'b1;
    in_ephemeral_key <= eph;
    in_message       <= msg;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_results.push_back(predict_encdec(eph, msg));
    n_sent++;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start and wait until the block has drained
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      CFG_MODULUS:   q_reg = val;
      CFG_GENERATOR: g_reg = val;
      CFG_PRIVKEY:   x_reg = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [FIELD_W-1:0] q, logic [FIELD_W-1:0] g,
                            logic [FIELD_W-1:0] x);
    wait_idle();
    cfg_write(CFG_MODULUS, q);
    cfg_write(CFG_GENERATOR, g);
    cfg_write(CFG_PRIVKEY, x);
  endtask

  // ---------------- result checker ----------------
  always @(negedge clk) begin
    elg_result_t exp_r, got;
    if (rst_n && out_valid) begin
      got = '{out_public_key, out_cipher_first, out_cipher_second,
              out_shared_key, out_decrypted, out_no_inverse};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $realtime, got);
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (exp_r.no_inverse) n_noinv++;
        if (got.public_key !== exp_r.public_key) begin
          errors++;
          $display("%0t: public_key exp %h got %h", $realtime,
                   exp_r.public_key, got.public_key);
        end
        if (got.cipher_first !== exp_r.cipher_first) begin
          errors++;
          $display("%0t: cipher_first exp %h got %h", $realtime,
                   exp_r.cipher_first, got.cipher_first);
        end
        if (got.cipher_second !== exp_r.cipher_second) begin
          errors++;
          $display("%0t: cipher_second exp %h got %h", $realtime,
                   exp_r.cipher_second, got.cipher_second);
        end
        if (got.shared_key !== exp_r.shared_key) begin
          errors++;
          $display("%0t: shared_key exp %h got %h", $realtime,
                   exp_r.shared_key, got.shared_key);
        end
        if (got.decrypted !== exp_r.decrypted) begin
          errors++;
          $display("%0t: decrypted exp %h got %h", $realtime,
                   exp_r.decrypted, got.decrypted);
        end
        if (got.no_inverse !== exp_r.no_inverse) begin
          errors++;
          $display("%0t: no_inverse exp %b got %b", $realtime,
                   exp_r.no_inverse, got.no_inverse);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------- tests ----------------
  // field extremes under the reset configuration
  task automatic test_reset_config();
    send_request(32'd0, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'd1, 32'd2147483647);
    send_request(32'd0, 32'd2147483648);
    send_request(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // moduli below two, composite moduli, zero generator and zero key
  task automatic test_corner_config();
    set_config(32'd0, 32'd5, 32'd3);
    send_request(32'd7, 32'd9);
    set_config(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd1);
    set_config(32'd2, 32'd3, 32'd0);
    send_request(32'd5, 32'd1);
    send_request(32'd0, 32'd3);
    // even modulus: even shared key has no inverse
    set_config(32'd4, 32'd2, 32'd1);
    send_request(32'd1, 32'd3);
    send_request(32'd0, 32'd3);
    // zero generator: shared key 0 unless exponent is zero
    set_config(32'd251, 32'd0, 32'd7);
    send_request(32'd3, 32'd10);
    send_request(32'd0, 32'd10);
    set_config(32'd251, 32'd0, 32'd0);
    send_request(32'd0, 32'd250);
    // ignored write must leave the registers alone
    wait_idle();
    cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
    send_request(32'd9, 32'd100);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_config(32'd4294967291, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
  endtask

  function automatic logic [FIELD_W-1:0] pick_modulus();
    case ($urandom_range(5))
      0: return 32'd2147483647;
      1: return 32'd4294967291;
      2: return 32'd65521;
      3: return 32'd251;
      4: return $urandom_range(2, 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_phase(int pct, int n);
    gap_pct = pct;
    for (int s = 0; s < 3; s++) begin
      set_config(pick_modulus(), $urandom, $urandom);
      for (int i = 0; i < n; i++) send_request($urandom, $urandom);
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_ephemeral_key <= '0;
    in_message       <= '0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_MODULUS;
    cfg_data         <= '0;
    q_reg = RST_MODULUS;
    g_reg = RST_GENERATOR;
    x_reg = RST_PRIVKEY;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_corner_config();
    test_random_phase(20, 11);
    test_random_phase(60, 11);
    test_random_phase(0, 11);
    wait_idle();

    $display("requests sent %0d, results checked %0d (%0d without inverse)",
             n_sent, n_checked, n_noinv);
    $display("covered reset config, small and composite moduli, random keys");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
